// ===== rtl/core/dadd_pkg.sv =====
package dadd_pkg;

  // Field widths of the input and result words.
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W = 5;
  localparam int unsigned COUNT_W = 22;

  // Default four-digit year limit.
  localparam int unsigned YEAR_LIMIT_DEF = 10000;

  // Leap-year cycle and the number of halving steps that reduce a start year
  // modulo that cycle (the quotient of a 14-bit year by 400 fits in 6 bits).
  localparam int unsigned LEAP_CYCLE = 400;
  localparam int unsigned CENTURY = 100;
  localparam int unsigned REDUCE_STEPS = 6;

  localparam int unsigned MONTH_JAN = 1;
  localparam int unsigned MONTH_FEB = 2;
  localparam int unsigned MONTH_DEC = 12;

  // Micro-operations of the sequencer.
  typedef enum logic [1:0] {
    OP_IDLE,
    OP_REDUCE,
    OP_WALK,
    OP_EMIT
  } op_t;

  typedef logic [3:0] step_t;

  // Named program steps.
  localparam step_t STEP_IDLE = 4'd0;
  localparam step_t STEP_WALK = 4'd7;
  localparam step_t STEP_EMIT = 4'd8;

  // One control word of the program.
  typedef struct packed {
    op_t         op;
    logic [2:0]  red_sh;
    step_t       jmp;
  } ctrl_t;

  // Status that the datapath returns to the sequencer.
  typedef struct packed {
    logic in_acc;
    logic zero_cnt;
    logic walk_end;
    logic out_free;
  } stat_t;

  // The program: take a word, reduce the year modulo 400 with six conditional
  // subtractions, walk months, then hand the result over; a zero count goes straight to it.
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    case (s)
      4'd0:    w = '{op: OP_IDLE,   red_sh: 3'd0, jmp: STEP_EMIT};
      4'd1:    w = '{op: OP_REDUCE, red_sh: 3'd5, jmp: STEP_IDLE};
      4'd2:    w = '{op: OP_REDUCE, red_sh: 3'd4, jmp: STEP_IDLE};
      4'd3:    w = '{op: OP_REDUCE, red_sh: 3'd3, jmp: STEP_IDLE};
      4'd4:    w = '{op: OP_REDUCE, red_sh: 3'd2, jmp: STEP_IDLE};
      4'd5:    w = '{op: OP_REDUCE, red_sh: 3'd1, jmp: STEP_IDLE};
      4'd6:    w = '{op: OP_REDUCE, red_sh: 3'd0, jmp: STEP_IDLE};
      4'd7:    w = '{op: OP_WALK,   red_sh: 3'd0, jmp: STEP_EMIT};
      4'd8:    w = '{op: OP_EMIT,   red_sh: 3'd0, jmp: STEP_IDLE};
      default: w = '{op: OP_IDLE,   red_sh: 3'd0, jmp: STEP_EMIT};
    endcase
    return w;
  endfunction

  // Days in a common-year month; codes outside 1 to 12 give 31 and are never walked.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:    len = 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/dadd_useq.sv =====
module dadd_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  dadd_pkg::stat_t stat,
  output dadd_pkg::ctrl_t ctrl
);

  dadd_pkg::step_t step_r;
  dadd_pkg::step_t step_nxt;
  dadd_pkg::step_t step_inc;

  // Current control word straight out of the program table.
  assign ctrl = dadd_pkg::ucode(step_r);
  assign step_inc = step_r + 4'd1;

  // Step counter: advance, hold while waiting, or take the jump.
  always_comb begin
    step_nxt = step_r;
    case (ctrl.op)
      dadd_pkg::OP_IDLE: begin
        if (stat.in_acc) begin
          step_nxt = stat.zero_cnt ? ctrl.jmp : step_inc;
        end
      end
      dadd_pkg::OP_REDUCE: begin
        step_nxt = step_inc;
      end
      dadd_pkg::OP_WALK: begin
        if (stat.walk_end) begin
          step_nxt = ctrl.jmp;
        end
      end
      dadd_pkg::OP_EMIT: begin
        if (stat.out_free) begin
          step_nxt = ctrl.jmp;
        end
      end
      default: begin
        step_nxt = dadd_pkg::STEP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= dadd_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== rtl/core/dadd_dpath.sv =====
module dadd_dpath #(
  parameter int unsigned YEAR_LIMIT = dadd_pkg::YEAR_LIMIT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dadd_pkg::ctrl_t ctrl,
  output dadd_pkg::stat_t stat,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [47:0]     in_tdata,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [23:0]     out_tdata,
  output logic [0:0]      out_tuser
);

  // The walked year must hold any 14-bit start year and every year below the limit.
  localparam int unsigned YMAX = (YEAR_LIMIT > (1 << dadd_pkg::YEAR_W)) ?
                                 YEAR_LIMIT : (1 << dadd_pkg::YEAR_W);
  localparam int unsigned YW = $clog2(YMAX);
  localparam int unsigned YW_I = dadd_pkg::YEAR_W;
  localparam int unsigned MW = dadd_pkg::MONTH_W;
  localparam int unsigned DW = dadd_pkg::DAY_W;
  localparam int unsigned NW = dadd_pkg::COUNT_W;

  logic [YW-1:0]   year_r,  year_nxt;
  logic [MW-1:0]   month_r, month_nxt;
  logic [DW-1:0]   day_r,   day_nxt;
  logic [NW-1:0]   cnt_r,   cnt_nxt;
  logic [YW_I-1:0] rem_r,   rem_nxt;
  logic            oob_r,   oob_nxt;
  logic            ovld_r,  ovld_nxt;
  logic [23:0]     odata_r, odata_nxt;
  logic            ouser_r, ouser_nxt;

  logic [YW_I-1:0] in_year;
  logic [MW-1:0]   in_month, in_month_clamp;
  logic [DW-1:0]   in_day;
  logic [NW-1:0]   in_cnt;

  logic [YW_I-1:0] rsub;
  logic            leap;
  logic [DW-1:0]   len;
  logic [DW-1:0]   room;
  logic            fits;
  logic [YW:0]     year_inc;
  logic            year_over;

  assign in_year  = in_tdata[13:0];
  assign in_month = in_tdata[17:14];
  assign in_day   = in_tdata[22:18];
  assign in_cnt   = in_tdata[44:23];

  // Month 0 walks as January and months above 12 as December.
  always_comb begin
    in_month_clamp = in_month;
    if (in_month == MW'(0)) begin
      in_month_clamp = MW'(dadd_pkg::MONTH_JAN);
    end else if (in_month > MW'(dadd_pkg::MONTH_DEC)) begin
      in_month_clamp = MW'(dadd_pkg::MONTH_DEC);
    end
  end

  assign in_tready = (ctrl.op == dadd_pkg::OP_IDLE);
  assign out_tvalid = ovld_r;
  assign out_tdata = odata_r;
  assign out_tuser = ouser_r;

  // Leap year: year mod 4 is the low two bits, rem_r holds year mod 400.
  assign leap = (year_r[1:0] == 2'd0) &&
                !((rem_r == YW_I'(dadd_pkg::CENTURY)) ||
                  (rem_r == YW_I'(2 * dadd_pkg::CENTURY)) ||
                  (rem_r == YW_I'(3 * dadd_pkg::CENTURY)));
  assign len = dadd_pkg::month_len(month_r) +
               DW'((month_r == MW'(dadd_pkg::MONTH_FEB)) && leap);
  assign room = (day_r > len) ? DW'(0) : (len - day_r);
  assign fits = (cnt_r <= NW'(room));
  assign year_inc = {1'b0, year_r} + (YW+1)'(1);
  assign year_over = (year_inc >= (YW+1)'(YEAR_LIMIT));

  assign rsub = YW_I'(dadd_pkg::LEAP_CYCLE) << ctrl.red_sh;

  assign stat.in_acc = in_tvalid && in_tready;
  assign stat.zero_cnt = (in_cnt == NW'(0));
  assign stat.walk_end = fits || ((month_r == MW'(dadd_pkg::MONTH_DEC)) && year_over);
  assign stat.out_free = !ovld_r || out_tready;

  // Datapath actions selected by the current micro-operation.
  always_comb begin
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    oob_nxt   = oob_r;
    ovld_nxt  = ovld_r && !out_tready;
    odata_nxt = odata_r;
    ouser_nxt = ouser_r;
    case (ctrl.op)
      dadd_pkg::OP_IDLE: begin
        if (stat.in_acc) begin
          year_nxt  = YW'(in_year);
          month_nxt = stat.zero_cnt ? in_month : in_month_clamp;
          day_nxt   = in_day;
          cnt_nxt   = in_cnt;
          rem_nxt   = in_year;
          oob_nxt   = 1'b0;
        end
      end
      dadd_pkg::OP_REDUCE: begin
        if (rem_r >= rsub) begin
          rem_nxt = rem_r - rsub;
        end
      end
      dadd_pkg::OP_WALK: begin
        if (fits) begin
          day_nxt = day_r + cnt_r[DW-1:0];
        end else begin
          cnt_nxt = cnt_r - NW'(room);
          day_nxt = DW'(0);
          if (month_r == MW'(dadd_pkg::MONTH_DEC)) begin
            month_nxt = MW'(dadd_pkg::MONTH_JAN);
            year_nxt  = year_inc[YW-1:0];
            rem_nxt   = (rem_r == YW_I'(dadd_pkg::LEAP_CYCLE - 1)) ?
                        YW_I'(0) : rem_r + YW_I'(1);
            oob_nxt   = year_over;
          end else begin
            month_nxt = month_r + MW'(1);
          end
        end
      end
      dadd_pkg::OP_EMIT: begin
        if (stat.out_free) begin
          ovld_nxt  = 1'b1;
          odata_nxt = oob_r ? 24'd0 :
                      {1'b0, day_r, month_r, year_r[YW_I-1:0]};
          ouser_nxt = oob_r;
        end
      end
      default: begin
        ovld_nxt = ovld_r;
      end
    endcase
  end

  // Control state is reset; the working and output payload are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= ovld_nxt;
    end
    year_r  <= year_nxt;
    month_r <= month_nxt;
    day_r   <= day_nxt;
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    oob_r   <= oob_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
  end

endmodule

// ===== rtl/core/date_add_days.sv =====
// Gregorian date adder: each input word carries a start date and a day count,
// and one result word gives the date that many days later, or the
// out_of_limit flag with zero date fields once the year reaches YEAR_LIMIT.
// A small microcoded sequencer drives the datapath: it takes the word,
// reduces the start year modulo 400 for the leap rule, walks the months one
// per cycle, and loads the output register. The walk stops once the year
// reaches YEAR_LIMIT, so the longest walk is from a start in year 0 with a
// large count. A zero count skips the reduction and the walk.
// The month walk, one month per cycle, is the longest part of the work.
// One word is worked at a time; the output register lets the next word start
// while a result still waits to be taken.
module date_add_days #(
  parameter int unsigned YEAR_LIMIT = dadd_pkg::YEAR_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // start_year, start_month, start_day, days_to_add
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // result_year, result_month, result_day
  output logic [0:0]  out_tuser   // out_of_limit
);

  dadd_pkg::ctrl_t ctrl;
  dadd_pkg::stat_t stat;

  dadd_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  dadd_dpath #(
    .YEAR_LIMIT (YEAR_LIMIT)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
